>>> design/fdl_pkg.sv
// Shared types, sizes and helpers for the fractional delay line.
// Used by fdl_ram and fractional_delay_line_core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fdl_pkg;

   localparam int DEPTH       = 8192;
   localparam int ADDR_BITS   = $clog2(DEPTH);
   localparam int LEN_BITS    = ADDR_BITS + 1;
   localparam int FRAC_BITS   = 8;
   localparam int SAMPLE_BITS = 16;
   localparam int DELAY_BITS  = 21;
   localparam int REQ_BITS    = ((SAMPLE_BITS + DELAY_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(4410);
   localparam logic [LEN_BITS-1:0] LEN_MIN   = LEN_BITS'(2);
   localparam logic [LEN_BITS-1:0] LEN_MAX   = LEN_BITS'(DEPTH);

   typedef logic [ADDR_BITS-1:0]          addr_type;
   typedef logic [LEN_BITS-1:0]           len_type;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [FRAC_BITS-1:0]          frac_type;
   typedef logic [DELAY_BITS-1:0]         delay_type;

   typedef struct packed {
      logic       we;
      addr_type   waddr;
      sample_type wdata;
      logic       re;
      addr_type   raddr_a;
      addr_type   raddr_b;
   } ram_req_type;

   function automatic len_type clamp_length(input len_type v);
      len_type r;
      if (v < LEN_MIN) begin
         r = LEN_MIN;
      end else if (v > LEN_MAX) begin
         r = LEN_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> design/fdl_ram.sv
// Sample store: one write port, two read ports, registered read data.
// Depends on fdl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fdl_ram (
   input  wire logic                clock,
   input  wire fdl_pkg::ram_req_type ram_req,
   output fdl_pkg::sample_type      rd_a_ff,
   output fdl_pkg::sample_type      rd_b_ff
);

   fdl_pkg::sample_type mem [fdl_pkg::DEPTH];

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         rd_a_ff <= mem[ram_req.raddr_a];
         rd_b_ff <= mem[ram_req.raddr_b];
      end
   end

endmodule
`default_nettype wire

>>> design/fractional_delay_line_core.sv
// Variable delay line with linear interpolation between two stored samples.
// Depends on fdl_pkg and fdl_ram.
// One transaction per cycle unless rsp_tready back-pressure stalls the stages.
// Six register stages: input, clamp, index wrap, dual read plus write, multiply, add.
// Store read and write share one edge, so later items see earlier writes directly.
// Reset: length 4410, write position 0, store reads as zero via a fill count.
`timescale 1ns / 1ps
`default_nettype none
module fractional_delay_line_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [15:0] sample_in, [36:16] delay_amount, [39:37] zero
   input  wire logic [fdl_pkg::REQ_BITS-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [15:0] sample_out
   output logic [fdl_pkg::RSP_BITS-1:0]       rsp_tdata,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [fdl_pkg::LEN_BITS-1:0]  csr_data
);

   localparam int SUM_BITS = fdl_pkg::LEN_BITS + 1;
   localparam int LIM_BITS = fdl_pkg::LEN_BITS + fdl_pkg::FRAC_BITS;
   localparam int PROD_BITS = fdl_pkg::SAMPLE_BITS + fdl_pkg::FRAC_BITS + 2;
   localparam int SH_BITS = PROD_BITS - fdl_pkg::FRAC_BITS;

   fdl_pkg::len_type  len_ff;
   fdl_pkg::addr_type wp_ff;
   fdl_pkg::len_type  fill_ff;

   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, vo_ff;
   logic rdy0, rdy1, rdy2, rdy3, rdy4, rdyo;
   logic acc, mv1, mv2, mv3, mv4, mvo;

   fdl_pkg::sample_type s0_smp_ff, s1_smp_ff, s2_smp_ff;
   fdl_pkg::delay_type  s0_dly_ff;
   fdl_pkg::addr_type   s0_wp_ff, s1_wp_ff, s2_wp_ff;
   fdl_pkg::addr_type   s1_whole_ff, s2_i1_ff;
   fdl_pkg::frac_type   s1_frac_ff, s2_frac_ff, s3_frac_ff;
   logic                s3_va_ff, s3_vb_ff;
   fdl_pkg::sample_type s4_y1_ff, s3_a, s3_b, rd_a_ff, rd_b_ff;
   logic signed [PROD_BITS-1:0] s4_prod_ff;
   fdl_pkg::sample_type out_ff;

   logic [LIM_BITS-1:0]  dly_ext, dly_lim, dly_c;
   fdl_pkg::addr_type    whole_in, i1_in, i2_in;
   fdl_pkg::frac_type    frac_in;
   logic [SUM_BITS-1:0]  sum_raw, sum_w;
   fdl_pkg::len_type     len_m1;
   logic signed [fdl_pkg::SAMPLE_BITS:0] diff_in;
   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [SH_BITS-1:0]   y_in;
   fdl_pkg::len_type     wp_next;
   fdl_pkg::ram_req_type ram_req;

   // stage handshake chain
   assign rdyo = !vo_ff || rsp_tready;
   assign rdy4 = !v4_ff || rdyo;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign rdy0 = !v0_ff || rdy1;
   assign req_tready = rdy0;
   assign acc = req_tvalid && rdy0;
   assign mv1 = v0_ff && rdy1;
   assign mv2 = v1_ff && rdy2;
   assign mv3 = v2_ff && rdy3;
   assign mv4 = v3_ff && rdy4;
   assign mvo = v4_ff && rdyo;

   assign csr_ready = 1'b1;
   assign rsp_tvalid = vo_ff;
   assign rsp_tdata = fdl_pkg::RSP_BITS'(out_ff);

   assign len_m1 = len_ff - fdl_pkg::LEN_BITS'(1);
   assign wp_next = fdl_pkg::LEN_BITS'(wp_ff) + fdl_pkg::LEN_BITS'(1);

   // delay clamp
   always_comb begin
      dly_ext = LIM_BITS'(s0_dly_ff);
      dly_lim = {len_ff, fdl_pkg::FRAC_BITS'(0)};
      if (dly_ext >= dly_lim) begin
         dly_c = {len_m1, fdl_pkg::FRAC_BITS'(0)};
      end else if (dly_ext < LIM_BITS'(1 << fdl_pkg::FRAC_BITS)) begin
         dly_c = LIM_BITS'(1 << fdl_pkg::FRAC_BITS);
      end else begin
         dly_c = dly_ext;
      end
      whole_in = dly_c[fdl_pkg::FRAC_BITS +: fdl_pkg::ADDR_BITS];
      frac_in  = dly_c[fdl_pkg::FRAC_BITS-1:0];
   end

   // tap index wrap
   always_comb begin
      sum_raw = SUM_BITS'(s1_wp_ff) + SUM_BITS'(len_ff) - SUM_BITS'(s1_whole_ff);
      if (sum_raw >= SUM_BITS'(len_ff)) begin
         sum_w = sum_raw - SUM_BITS'(len_ff);
      end else begin
         sum_w = sum_raw;
      end
      i1_in = sum_w[fdl_pkg::ADDR_BITS-1:0];
      if (s2_i1_ff == '0) begin
         i2_in = len_m1[fdl_pkg::ADDR_BITS-1:0];
      end else begin
         i2_in = s2_i1_ff - fdl_pkg::ADDR_BITS'(1);
      end
   end

   always_comb begin
      ram_req.we      = mv3;
      ram_req.waddr   = s2_wp_ff;
      ram_req.wdata   = s2_smp_ff;
      ram_req.re      = mv3;
      ram_req.raddr_a = s2_i1_ff;
      ram_req.raddr_b = i2_in;
   end

   fdl_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_a_ff (rd_a_ff),
      .rd_b_ff (rd_b_ff)
   );

   // interpolation
   always_comb begin
      s3_a    = s3_va_ff ? rd_a_ff : '0;
      s3_b    = s3_vb_ff ? rd_b_ff : '0;
      diff_in = (fdl_pkg::SAMPLE_BITS+1)'(s3_b) - (fdl_pkg::SAMPLE_BITS+1)'(s3_a);
      prod_in = PROD_BITS'($signed({1'b0, s3_frac_ff})) * PROD_BITS'(diff_in);
      y_in    = SH_BITS'(s4_y1_ff) + SH_BITS'(s4_prod_ff >>> fdl_pkg::FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= fdl_pkg::clamp_length(fdl_pkg::LEN_RESET);
         wp_ff   <= '0;
         fill_ff <= '0;
         v0_ff   <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         vo_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            len_ff <= fdl_pkg::clamp_length(csr_data);
            wp_ff  <= '0;
         end else if (acc) begin
            if (wp_next >= len_ff) begin
               wp_ff <= '0;
            end else begin
               wp_ff <= wp_next[fdl_pkg::ADDR_BITS-1:0];
            end
         end
         if (mv3 && (fdl_pkg::LEN_BITS'(s2_wp_ff) >= fill_ff)) begin
            fill_ff <= fdl_pkg::LEN_BITS'(s2_wp_ff) + fdl_pkg::LEN_BITS'(1);
         end
         if (rdy0) v0_ff <= req_tvalid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdyo) vo_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s0_smp_ff <= req_tdata[fdl_pkg::SAMPLE_BITS-1:0];
         s0_dly_ff <= req_tdata[fdl_pkg::SAMPLE_BITS +: fdl_pkg::DELAY_BITS];
         s0_wp_ff  <= wp_ff;
      end
      if (mv1) begin
         s1_smp_ff   <= s0_smp_ff;
         s1_wp_ff    <= s0_wp_ff;
         s1_whole_ff <= whole_in;
         s1_frac_ff  <= frac_in;
      end
      if (mv2) begin
         s2_smp_ff  <= s1_smp_ff;
         s2_wp_ff   <= s1_wp_ff;
         s2_i1_ff   <= i1_in;
         s2_frac_ff <= s1_frac_ff;
      end
      if (mv3) begin
         s3_va_ff   <= fdl_pkg::LEN_BITS'(s2_i1_ff) < fill_ff;
         s3_vb_ff   <= fdl_pkg::LEN_BITS'(i2_in) < fill_ff;
         s3_frac_ff <= s2_frac_ff;
      end
      if (mv4) begin
         s4_y1_ff   <= s3_a;
         s4_prod_ff <= prod_in;
      end
      if (mvo) begin
         out_ff <= y_in[fdl_pkg::SAMPLE_BITS-1:0];
      end
   end

   a_wp_in_range: assert property (@(posedge clock) disable iff (reset)
      fdl_pkg::LEN_BITS'(wp_ff) < len_ff)
      else $error("write position outside active length");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      (len_ff >= fdl_pkg::LEN_MIN) && (len_ff <= fdl_pkg::LEN_MAX))
      else $error("active length outside clamp range");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= fdl_pkg::LEN_MAX)
      else $error("fill count beyond store depth");

   a_tap_not_write: assert property (@(posedge clock) disable iff (reset)
      mv3 |-> (s2_i1_ff != s2_wp_ff))
      else $error("first tap collides with write of the same transaction");

   a_wp_advance: assert property (@(posedge clock) disable iff (reset)
      (acc && !csr_valid && (wp_next < len_ff)) |=>
         (fdl_pkg::LEN_BITS'(wp_ff) == $past(wp_next)))
      else $error("write position did not advance");

endmodule
`default_nettype wire
